// File: rtl/drld_pkg.sv
`timescale 1ns / 1ps
// drld_pkg: shared constants and result type for the data-run list decoder
// no dependencies; used by drld_decode and data_run_list_decoder_top

package drld_pkg;

    // width in which the running start cluster wraps
    localparam int unsigned CLUSTER_WIDTH = 64;

    // byte and field sizes
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned FIELD_W  = 64;
    localparam int unsigned NIBBLE_W = 4;
    localparam int unsigned MAX_FIELD_BYTES = FIELD_W / BYTE_W;

    typedef struct packed {
        logic [FIELD_W-1:0] run_base;
        logic [FIELD_W-1:0] run_len;
        logic               list_end;
    } drld_result_t;

endpackage

// File: rtl/drld_decode.sv
`timescale 1ns / 1ps
// drld_decode: run-list state machine, field gather, offset add and result register
// depends on drld_pkg

module drld_decode (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  item_valid,
    input  logic [7:0]            item_byte,
    input  logic                  item_start,
    input  logic                  m_ready,
    output logic                  item_take,
    output logic                  m_valid,
    output drld_pkg::drld_result_t m_result
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_COUNT,
        PH_OFFSET,
        PH_IDLE
    } phase_t;

    localparam int unsigned CW = drld_pkg::CLUSTER_WIDTH;
    localparam int unsigned FW = drld_pkg::FIELD_W;
    localparam int unsigned NW = drld_pkg::NIBBLE_W;

    phase_t                 phase_reg, phase_next;
    logic [NW-1:0]          count_bytes_reg, count_bytes_next;
    logic [NW-1:0]          offset_bytes_reg, offset_bytes_next;
    logic [NW-1:0]          byte_index_reg, byte_index_next;
    logic [FW-1:0]          count_accum_reg, count_accum_next;
    logic [FW-1:0]          offset_accum_reg, offset_accum_next;
    logic [CW-1:0]          prev_cluster_reg, prev_cluster_next;
    logic                   m_valid_reg, m_valid_next;
    drld_pkg::drld_result_t result_reg, result_next;

    logic                   out_free;
    logic                   emit;
    phase_t                 phase_eff;
    logic [CW-1:0]          prev_eff;
    logic [NW-1:0]          index_inc;
    logic [FW-1:0]          offset_merged;
    logic [FW-1:0]          delta;
    logic [CW-1:0]          sum;

    // the result register is free when empty or being drained
    assign out_free  = !m_valid_reg || m_ready;
    assign item_take = item_valid && out_free;

    // new list start clears the running cluster and forces a header
    assign phase_eff = item_start ? PH_HEADER : phase_reg;
    assign prev_eff  = item_start ? '0 : prev_cluster_reg;
    assign index_inc = byte_index_reg + 1'b1;

    // offset with the current byte merged in, bytes past the eighth dropped
    always_comb begin
        offset_merged = offset_accum_reg;
        if (!byte_index_reg[NW-1]) begin
            offset_merged[8*byte_index_reg[NW-2:0] +: 8] = item_byte;
        end
    end

    // sign-extend the offset from its top gathered byte
    always_comb begin
        case (offset_bytes_reg)
            4'd1:    delta = FW'(signed'(offset_merged[7:0]));
            4'd2:    delta = FW'(signed'(offset_merged[15:0]));
            4'd3:    delta = FW'(signed'(offset_merged[23:0]));
            4'd4:    delta = FW'(signed'(offset_merged[31:0]));
            4'd5:    delta = FW'(signed'(offset_merged[39:0]));
            4'd6:    delta = FW'(signed'(offset_merged[47:0]));
            4'd7:    delta = FW'(signed'(offset_merged[55:0]));
            default: delta = offset_merged;
        endcase
    end

    // running start cluster, wraps at the cluster width
    assign sum = prev_eff + delta[CW-1:0];

    // next-state and result decode
    always_comb begin
        phase_next        = phase_eff;
        count_bytes_next  = count_bytes_reg;
        offset_bytes_next = offset_bytes_reg;
        byte_index_next   = byte_index_reg;
        count_accum_next  = count_accum_reg;
        offset_accum_next = offset_accum_reg;
        prev_cluster_next = prev_eff;
        emit              = 1'b0;
        result_next       = result_reg;

        unique case (phase_eff)
            PH_HEADER: begin
                count_bytes_next  = item_byte[3:0];
                offset_bytes_next = item_byte[7:4];
                byte_index_next   = '0;
                count_accum_next  = '0;
                offset_accum_next = '0;
                if (item_byte[3:0] == '0 || item_byte[7:4] == '0) begin
                    phase_next           = PH_IDLE;
                    emit                 = 1'b1;
                    result_next.run_base = '0;
                    result_next.run_len  = '0;
                    result_next.list_end = 1'b1;
                end else begin
                    phase_next = PH_COUNT;
                end
            end
            PH_COUNT: begin
                if (!byte_index_reg[NW-1]) begin
                    count_accum_next[8*byte_index_reg[NW-2:0] +: 8] = item_byte;
                end
                byte_index_next = index_inc;
                if (index_inc >= count_bytes_reg) begin
                    byte_index_next = '0;
                    phase_next      = PH_OFFSET;
                end
            end
            PH_OFFSET: begin
                offset_accum_next = offset_merged;
                byte_index_next   = index_inc;
                if (index_inc >= offset_bytes_reg) begin
                    prev_cluster_next    = sum;
                    byte_index_next      = '0;
                    phase_next           = PH_HEADER;
                    emit                 = 1'b1;
                    result_next.run_base = FW'(signed'(sum));
                    result_next.run_len  = FW'(count_accum_reg[CW-1:0]);
                    result_next.list_end = 1'b0;
                end
            end
            PH_IDLE: begin
                phase_next = PH_IDLE;
            end
        endcase

        if (item_take && emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // state and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HEADER;
            count_bytes_reg  <= '0;
            offset_bytes_reg <= '0;
            byte_index_reg   <= '0;
            count_accum_reg  <= '0;
            offset_accum_reg <= '0;
            prev_cluster_reg <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (item_take) begin
                phase_reg        <= phase_next;
                count_bytes_reg  <= count_bytes_next;
                offset_bytes_reg <= offset_bytes_next;
                byte_index_reg   <= byte_index_next;
                count_accum_reg  <= count_accum_next;
                offset_accum_reg <= offset_accum_next;
                prev_cluster_reg <= prev_cluster_next;
            end
        end
        if (item_take && emit) begin
            result_reg <= result_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = result_reg;

endmodule

// File: rtl/data_run_list_decoder_top.sv
`timescale 1ns / 1ps
// data_run_list_decoder_top: input register plus run-list decode stage
// result path: a run's last byte is held in the input register, then its result in the decode result register
// throughput: one list byte per cycle; a request stalls only while the result waits
// reset: synchronous active-low aresetn empties both registers and returns to header
// depends on drld_pkg and drld_decode

module data_run_list_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_list_byte,
    input  logic        s_list_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_run_start_cluster,
    output logic [63:0] m_run_cluster_count,
    output logic        m_list_end
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_start_reg;
    logic                   item_take;
    drld_pkg::drld_result_t result;

    assign s_ready = !in_valid_reg || item_take;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (item_take) begin
            in_valid_reg <= 1'b0;
        end
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_list_byte;
            in_start_reg <= s_list_start;
        end
    end

    drld_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (in_valid_reg),
        .item_byte  (in_byte_reg),
        .item_start (in_start_reg),
        .m_ready    (m_ready),
        .item_take  (item_take),
        .m_valid    (m_valid),
        .m_result   (result)
    );

    assign m_run_start_cluster = result.run_base;
    assign m_run_cluster_count = result.run_len;
    assign m_list_end          = result.list_end;

endmodule

// File: rtl/drld_checker.sv
`timescale 1ns / 1ps
// drld_checker: port-level assertions for the data-run list decoder
// bound to data_run_list_decoder_top; no package dependency

module drld_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_run_start_cluster,
    input logic [63:0] m_run_cluster_count,
    input logic        m_list_end
);

    // a stalled result stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_run_start_cluster) &&
            $stable(m_run_cluster_count) && $stable(m_list_end))
        else $error("result payload changed while stalled");

    // an end marker carries no run
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_list_end |-> m_run_start_cluster == 64'd0 &&
            m_run_cluster_count == 64'd0)
        else $error("end marker carries run data");

    // reset leaves the block empty and ready for a request
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not empty after reset");

endmodule

bind data_run_list_decoder_top drld_checker u_drld_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .s_ready             (s_ready),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_run_start_cluster (m_run_start_cluster),
    .m_run_cluster_count (m_run_cluster_count),
    .m_list_end          (m_list_end)
);

// File: tb/data_run_list_decoder_top_tb.sv
`timescale 1ns / 1ps
// data_run_list_decoder_top_tb: self-checking bench for the data-run list decoder
// streams directed and random run lists, predicts runs and list ends, checks each result
// depends on drld_pkg and data_run_list_decoder_top

module data_run_list_decoder_top_tb;

    localparam int unsigned RANDOM_BYTES = 1400;
    localparam int unsigned IDLE_LIMIT   = 5000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam logic [63:0] CLUSTER_MASK =
        (drld_pkg::CLUSTER_WIDTH >= 64) ? '1 :
        ((64'd1 << drld_pkg::CLUSTER_WIDTH) - 64'd1);

    // decoder walk through one run list
    typedef enum logic [1:0] {
        EXP_HEADER,
        EXP_COUNT,
        EXP_OFFSET,
        LIST_DONE
    } walk_t;

    typedef struct {
        logic [7:0] data;
        logic       first;
    } list_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_list_byte = '0;
    logic        s_list_start = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_run_start_cluster;
    logic [63:0] m_run_cluster_count;
    logic        m_list_end;

    data_run_list_decoder_top uut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_list_byte         (s_list_byte),
        .s_list_start        (s_list_start),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_run_start_cluster (m_run_start_cluster),
        .m_run_cluster_count (m_run_cluster_count),
        .m_list_end          (m_list_end)
    );

    // pending requests and expected results
    list_byte_t             pending_bytes[$];
    drld_pkg::drld_result_t expected_runs[$];

    // predictor state
    walk_t       dec_phase    = EXP_HEADER;
    logic [3:0]  count_len    = '0;
    logic [3:0]  offset_len   = '0;
    logic [3:0]  field_pos    = '0;
    logic [63:0] count_sum    = '0;
    logic [63:0] offset_sum   = '0;
    logic [63:0] prev_cluster = '0;

    int unsigned mismatches  = 0;
    int unsigned bytes_sent  = 0;
    int unsigned runs_seen   = 0;
    int unsigned ends_seen   = 0;
    int unsigned send_wait   = 0;
    int unsigned take_wait   = 0;
    int unsigned idle_cycles = 0;
    logic        quiet       = 1'b0;

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // reset held low from the start, then released
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // occasional stretches with no idling on either side
    always @(negedge aclk) begin
        if ($urandom_range(0, 299) == 0) begin
            quiet <= ~quiet;
        end
    end

    function automatic int unsigned draw_wait();
        if (quiet) begin
            return 0;
        end
        if ($urandom_range(0, 2) == 0) begin
            return $urandom_range(0, 15);
        end
        return $urandom_range(0, 2);
    endfunction

    // sign-extend the low bits of a value to 64 bits
    function automatic logic [63:0] widen_signed(input logic [63:0] value,
                                                 input int unsigned bits);
        logic [63:0] top;
        logic [63:0] low_mask;
        if (bits >= 64 || bits == 0) begin
            return value;
        end
        top      = 64'd1 << (bits - 1);
        low_mask = (64'd1 << bits) - 64'd1;
        return ((value & low_mask) ^ top) - top;
    endfunction

    // advance the predicted decoder by one accepted byte
    task automatic decode_byte(input logic [7:0] b, input logic st);
        drld_pkg::drld_result_t res;
        logic [63:0]  delta;
        logic [63:0]  sum;
        int unsigned  nbits;
        if (st) begin
            prev_cluster = '0;
            dec_phase    = EXP_HEADER;
        end
        case (dec_phase)
            EXP_HEADER: begin
                count_len  = b[3:0];
                offset_len = b[7:4];
                field_pos  = '0;
                count_sum  = '0;
                offset_sum = '0;
                if (count_len == 0 || offset_len == 0) begin
                    dec_phase    = LIST_DONE;
                    res.run_base = '0;
                    res.run_len  = '0;
                    res.list_end = 1'b1;
                    expected_runs.push_back(res);
                end else begin
                    dec_phase = EXP_COUNT;
                end
            end
            EXP_COUNT: begin
                // bytes past the eighth are dropped
                if (field_pos < 8) begin
                    count_sum |= {56'd0, b} << (8 * int'(field_pos));
                end
                field_pos = field_pos + 4'd1;
                if (field_pos >= count_len) begin
                    field_pos = '0;
                    dec_phase = EXP_OFFSET;
                end
            end
            EXP_OFFSET: begin
                if (field_pos < 8) begin
                    offset_sum |= {56'd0, b} << (8 * int'(field_pos));
                end
                field_pos = field_pos + 4'd1;
                if (field_pos >= offset_len) begin
                    nbits        = (offset_len >= 8) ? 64 : 8 * int'(offset_len);
                    delta        = widen_signed(offset_sum, nbits);
                    sum          = (prev_cluster + delta) & CLUSTER_MASK;
                    prev_cluster = sum;
                    field_pos    = '0;
                    dec_phase    = EXP_HEADER;
                    res.run_base = widen_signed(sum, drld_pkg::CLUSTER_WIDTH);
                    res.run_len  = count_sum & CLUSTER_MASK;
                    res.list_end = 1'b0;
                    expected_runs.push_back(res);
                end
            end
            default: begin
                // list over: bytes are ignored until a new list starts
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] %s: got 0x%016h, want 0x%016h", $realtime, what, got, want);
        mismatches++;
    endtask

    // driver: presents queued requests with random gaps
    always @(posedge aclk) begin
        list_byte_t nxt;
        if (!aresetn) begin
            s_valid      <= 1'b0;
            s_list_byte  <= '0;
            s_list_start <= 1'b0;
            send_wait    = 0;
        end else begin
            if (s_valid && s_ready) begin
                decode_byte(s_list_byte, s_list_start);
                bytes_sent++;
            end
            if (!s_valid || s_ready) begin
                if (send_wait != 0) begin
                    send_wait--;
                    s_valid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    nxt = pending_bytes.pop_front();
                    s_list_byte  <= nxt.data;
                    s_list_start <= nxt.first;
                    s_valid      <= 1'b1;
                    send_wait    = draw_wait();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back-pressure, compares each result with the oldest expectation
    always @(posedge aclk) begin
        drld_pkg::drld_result_t want;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            take_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_runs.size() == 0) begin
                    report_mismatch("result with nothing expected", m_run_start_cluster, '0);
                end else begin
                    want = expected_runs.pop_front();
                    if (m_run_start_cluster !== want.run_base) begin
                        report_mismatch("run_start_cluster", m_run_start_cluster,
                                        want.run_base);
                    end
                    if (m_run_cluster_count !== want.run_len) begin
                        report_mismatch("run_cluster_count", m_run_cluster_count,
                                        want.run_len);
                    end
                    if (m_list_end !== want.list_end) begin
                        report_mismatch("list_end", {63'd0, m_list_end},
                                        {63'd0, want.list_end});
                    end
                    if (want.list_end) begin
                        ends_seen++;
                    end else begin
                        runs_seen++;
                    end
                end
                take_wait = draw_wait();
            end else if (take_wait != 0) begin
                take_wait--;
            end
            m_ready <= (take_wait == 0);
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // stimulus helpers
    task automatic push_byte(input logic [7:0] b, input logic st);
        list_byte_t item;
        item.data  = b;
        item.first = st;
        pending_bytes.push_back(item);
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 11))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [3:0] rand_field_len();
        if ($urandom_range(0, 9) < 8) begin
            return 4'($urandom_range(1, 4));
        end
        return 4'($urandom_range(1, 15));
    endfunction

    // one well-formed run, with a rare list start landing inside it
    task automatic add_run(input logic st, inout int unsigned n);
        logic [3:0] cl;
        logic [3:0] ol;
        cl = rand_field_len();
        ol = rand_field_len();
        push_byte({ol, cl}, st);
        n++;
        repeat (int'(cl) + int'(ol)) begin
            push_byte(rand_byte(), ($urandom_range(0, 79) == 0));
            n++;
        end
    endtask

    // header with at least one zero nibble
    task automatic add_terminator(input logic st, inout int unsigned n);
        case ($urandom_range(0, 2))
            0:       push_byte(8'h00, st);
            1:       push_byte({4'($urandom_range(0, 15)), 4'h0}, st);
            default: push_byte({4'h0, 4'($urandom_range(0, 15))}, st);
        endcase
        n++;
    endtask

    // fills the request queue, then waits for the drain and reports
    initial begin
        int unsigned stim_count;
        int unsigned n_runs;
        logic        first;
        stim_count = 0;

        // first list after reset, headers taken without a list start
        push_byte(8'h11, 1'b0);
        push_byte(8'h05, 1'b0);
        push_byte(8'h7F, 1'b0);
        // most negative one-byte offset walks the cluster below zero
        push_byte(8'h11, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b0);
        // terminator by zero count nibble, then a byte that must be ignored
        push_byte(8'h10, 1'b0);
        push_byte(8'hA5, 1'b0);
        // new list with the longest offset field: bytes past the eighth dropped
        push_byte(8'hF1, 1'b1);
        push_byte(8'hFF, 1'b0);
        repeat (7) push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b0);
        repeat (7) push_byte(8'h55, 1'b0);

        // random lists, mostly well formed
        while (stim_count < RANDOM_BYTES) begin
            n_runs = $urandom_range(0, 6);
            first  = 1'b1;
            repeat (n_runs) begin
                add_run(first, stim_count);
                first = 1'b0;
            end
            if ($urandom_range(0, 7) != 0) begin
                add_terminator(first, stim_count);
                // trailing noise after the list end
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)), 1'b0);
                end
            end else if ($urandom_range(0, 1) == 0) begin
                // stray bytes parsed as a broken run
                repeat ($urandom_range(1, 5)) begin
                    push_byte(8'($urandom_range(0, 255)), 1'b0);
                    stim_count++;
                end
            end
        end

        // drain
        do begin
            @(negedge aclk);
        end while (pending_bytes.size() != 0 || s_valid || expected_runs.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("sent %0d list bytes; checked %0d runs and %0d list ends",
                 bytes_sent, runs_seen, ends_seen);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/drld_pkg.sv
rtl/drld_decode.sv
rtl/data_run_list_decoder_top.sv
rtl/drld_checker.sv
tb/data_run_list_decoder_top_tb.sv
